FILE: sv/rsr_pkg.sv
// shared types and state codes for the replacement-selection run generator
package rsr_pkg;

   localparam int TAG_W   = 32;
   localparam int DEPT_W  = 64;
   localparam int SCORE_W = 32;
   localparam int RUN_W   = 16;
   localparam int SEQ_W   = 32;
   localparam int CAP_W   = 11;

   localparam logic [CAP_W-1:0] CAP_RESET = 11'd1024;
   localparam logic [RUN_W-1:0] RUN_MAX   = 16'hFFFF;

   typedef struct packed {
      logic [TAG_W-1:0]          tag;
      logic [DEPT_W-1:0]         dept;
      logic signed [SCORE_W-1:0] score;
      logic [RUN_W-1:0]          run;
      logic [SEQ_W-1:0]          seq;
   } entry_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_UP_RD,
      ST_UP_CMP,
      ST_TOP,
      ST_LAST,
      ST_DN_L,
      ST_DN_R,
      ST_DN_RC,
      ST_DN_C
   } state_type;

endpackage

FILE: sv/rsr_ram.sv
// generic single write port ram with registered read
module rsr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: sv/rsr_cmp.sv
// heap order compare: run asc, dept asc, score desc, arrival asc
module rsr_cmp (
   input  rsr_pkg::entry_type a,
   input  rsr_pkg::entry_type b,
   output logic               less
);

   always_comb begin
      if (a.run != b.run) begin
         less = a.run < b.run;
      end else if (a.dept != b.dept) begin
         less = a.dept < b.dept;
      end else if (a.score != b.score) begin
         less = a.score > b.score;
      end else begin
         less = a.seq < b.seq;
      end
   end

endmodule

FILE: sv/replacement_selection_runs_core.sv
// top level of the replacement-selection run generator
// usage:
//  - req channel carries one transaction per record (mode 0) or drain (mode 1);
//    req_stall is high whenever the sequencer is busy with the previous one
//  - while the heap holds fewer entries than the capacity in use a record is
//    inserted with run 0 and gives no result; once full it emits the top entry
//    and replaces it; a drain pops the top; a drain on an empty heap is dropped
//  - rsp channel carries the emitted record; the result sits in an output
//    register so a stalled receiver only holds the block when the next
//    result is ready to be written
//  - the result is loaded into the output register from the top read once rsp is free
//  - one heap compare unit and one ram read port are shared, and a new
//    transaction is taken only once the previous one is done; an insert climbs
//    level by level (parent read, compare), a replace or drain sifts down level
//    by level (left and right child read, compare)
//  - reset (synchronous) empties the heap, clears the arrival counter and
//    sets capacity to 1024; no clearing pass, heap ram is never read unwritten
//  - csr_wr_en writes capacity_in_use, 0 acts as 1, above CAPACITY as CAPACITY
module replacement_selection_runs_core #(
   parameter int CAPACITY = 1024
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic [10:0] csr_wr_data,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_mode,
   input  logic [31:0] req_record_tag,
   input  logic [63:0] req_dept_key,
   input  logic signed [31:0] req_score,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_out_tag,
   output logic [63:0] rsp_out_dept,
   output logic signed [31:0] rsp_out_score,
   output logic [15:0] rsp_run_number,
   output logic        rsp_heap_now_empty
);

   localparam int AW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);
   localparam int IW = AW + 2;
   localparam int EW = $bits(rsr_pkg::entry_type);

   rsr_pkg::state_type state_ff, state_in;
   logic               drain_ff, drain_in;
   rsr_pkg::entry_type new_ff, new_in;
   rsr_pkg::entry_type cur_ff, cur_in;
   rsr_pkg::entry_type child_ff, child_in;
   logic [AW-1:0]      idx_ff, idx_in;
   logic [AW-1:0]      cidx_ff, cidx_in;
   logic [CW-1:0]      n_ff, n_in;
   logic [CW-1:0]      count_ff, count_in;
   logic [31:0]        arr_ff, arr_in;
   logic [10:0]        cap_ff;

   logic               rsp_valid_ff, rsp_valid_in;
   rsr_pkg::entry_type rsp_ent_ff, rsp_ent_in;
   logic               rsp_empty_ff, rsp_empty_in;

   // heap ram and shared compare unit
   logic               wr_en, rd_en;
   logic [AW-1:0]      wr_addr, rd_addr;
   rsr_pkg::entry_type wr_data, rd_data;
   rsr_pkg::entry_type cmp_a, cmp_b;
   logic               cmp_less;

   logic [EW-1:0] rd_bits;

   rsr_ram #(.WIDTH(EW), .DEPTH(CAPACITY)) u_heap (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_bits)
   );
   assign rd_data = rsr_pkg::entry_type'(rd_bits);

   rsr_cmp u_cmp (
      .a    (cmp_a),
      .b    (cmp_b),
      .less (cmp_less)
   );

   // effective capacity after clamping
   logic [31:0]   cap_w;
   logic [CW-1:0] cap_eff;
   always_comb begin
      cap_w = (cap_ff == '0) ? 32'd1 : {21'd0, cap_ff};
      if (cap_w > 32'(CAPACITY)) begin
         cap_w = 32'(CAPACITY);
      end
      cap_eff = cap_w[CW-1:0];
   end

   // child and parent indexes of the current hole
   logic [IW-1:0] lchild, rchild, n_ext;
   logic [AW-1:0] parent;
   assign lchild = (IW'(idx_ff) << 1) + IW'(1);
   assign rchild = lchild + IW'(1);
   assign n_ext  = IW'(n_ff);
   assign parent = (idx_ff - AW'(1)) >> 1;

   logic out_free;
   assign out_free = !rsp_valid_ff || !rsp_stall;

   logic [15:0] next_run;

   always_comb begin
      state_in     = state_ff;
      drain_in     = drain_ff;
      new_in       = new_ff;
      cur_in       = cur_ff;
      child_in     = child_ff;
      idx_in       = idx_ff;
      cidx_in      = cidx_ff;
      n_in         = n_ff;
      count_in     = count_ff;
      arr_in       = arr_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_ent_in   = rsp_ent_ff;
      rsp_empty_in = rsp_empty_ff;
      wr_en        = 1'b0;
      wr_addr      = idx_ff;
      wr_data      = cur_ff;
      rd_en        = 1'b0;
      rd_addr      = '0;
      cmp_a        = cur_ff;
      cmp_b        = rd_data;
      next_run     = rd_data.run;

      unique case (state_ff)
         rsr_pkg::ST_IDLE: begin
            if (req_valid) begin
               new_in.tag   = req_record_tag;
               new_in.dept  = req_dept_key;
               new_in.score = req_score;
               new_in.run   = '0;
               new_in.seq   = arr_ff;
               drain_in     = req_mode;
               if (req_mode) begin
                  if (count_ff != '0) begin
                     rd_en    = 1'b1;
                     state_in = rsr_pkg::ST_TOP;
                  end
               end else if (count_ff < cap_eff) begin
                  // fill phase: climb from the new leaf
                  cur_in.tag   = req_record_tag;
                  cur_in.dept  = req_dept_key;
                  cur_in.score = req_score;
                  cur_in.run   = '0;
                  cur_in.seq   = arr_ff;
                  arr_in       = arr_ff + 32'd1;
                  idx_in       = AW'(count_ff);
                  count_in     = count_ff + CW'(1);
                  state_in     = rsr_pkg::ST_UP_RD;
               end else begin
                  rd_en    = 1'b1;
                  state_in = rsr_pkg::ST_TOP;
               end
            end
         end
         rsr_pkg::ST_UP_RD: begin
            if (idx_ff == '0) begin
               wr_en    = 1'b1;
               state_in = rsr_pkg::ST_IDLE;
            end else begin
               rd_en    = 1'b1;
               rd_addr  = parent;
               cidx_in  = parent;
               state_in = rsr_pkg::ST_UP_CMP;
            end
         end
         rsr_pkg::ST_UP_CMP: begin
            wr_en = 1'b1;
            if (cmp_less) begin
               wr_data  = rd_data;
               idx_in   = cidx_ff;
               state_in = rsr_pkg::ST_UP_RD;
            end else begin
               state_in = rsr_pkg::ST_IDLE;
            end
         end
         rsr_pkg::ST_TOP: begin
            // new record key against the top key, with the top's run and arrival masked
            cmp_a     = new_ff;
            cmp_b     = rd_data;
            cmp_b.run = '0;
            cmp_b.seq = '0;
            if (cmp_less && rd_data.run != rsr_pkg::RUN_MAX) begin
               next_run = rd_data.run + 16'd1;
            end
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_ent_in   = rd_data;
               rsp_empty_in = drain_ff && (count_ff == CW'(1));
               idx_in       = '0;
               if (drain_ff) begin
                  count_in = count_ff - CW'(1);
                  n_in     = count_ff - CW'(1);
                  if (count_ff == CW'(1)) begin
                     state_in = rsr_pkg::ST_IDLE;
                  end else begin
                     rd_en    = 1'b1;
                     rd_addr  = AW'(count_ff - CW'(1));
                     state_in = rsr_pkg::ST_LAST;
                  end
               end else begin
                  cur_in     = new_ff;
                  cur_in.run = next_run;
                  arr_in     = arr_ff + 32'd1;
                  n_in       = count_ff;
                  state_in   = rsr_pkg::ST_DN_L;
               end
            end
         end
         rsr_pkg::ST_LAST: begin
            cur_in   = rd_data;
            state_in = rsr_pkg::ST_DN_L;
         end
         rsr_pkg::ST_DN_L: begin
            if (lchild >= n_ext) begin
               wr_en    = 1'b1;
               state_in = rsr_pkg::ST_IDLE;
            end else begin
               rd_en    = 1'b1;
               rd_addr  = lchild[AW-1:0];
               cidx_in  = lchild[AW-1:0];
               state_in = rsr_pkg::ST_DN_R;
            end
         end
         rsr_pkg::ST_DN_R: begin
            child_in = rd_data;
            if (rchild < n_ext) begin
               rd_en    = 1'b1;
               rd_addr  = rchild[AW-1:0];
               state_in = rsr_pkg::ST_DN_RC;
            end else begin
               state_in = rsr_pkg::ST_DN_C;
            end
         end
         rsr_pkg::ST_DN_RC: begin
            cmp_a = rd_data;
            cmp_b = child_ff;
            if (cmp_less) begin
               child_in = rd_data;
               cidx_in  = rchild[AW-1:0];
            end
            state_in = rsr_pkg::ST_DN_C;
         end
         rsr_pkg::ST_DN_C: begin
            cmp_a = child_ff;
            cmp_b = cur_ff;
            wr_en = 1'b1;
            if (cmp_less) begin
               wr_data  = child_ff;
               idx_in   = cidx_ff;
               state_in = rsr_pkg::ST_DN_L;
            end else begin
               state_in = rsr_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = rsr_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= rsr_pkg::ST_IDLE;
         count_ff     <= '0;
         arr_ff       <= '0;
         cap_ff       <= rsr_pkg::CAP_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         arr_ff       <= arr_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            cap_ff <= csr_wr_data;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      drain_ff     <= drain_in;
      new_ff       <= new_in;
      cur_ff       <= cur_in;
      child_ff     <= child_in;
      idx_ff       <= idx_in;
      cidx_ff      <= cidx_in;
      n_ff         <= n_in;
      rsp_ent_ff   <= rsp_ent_in;
      rsp_empty_ff <= rsp_empty_in;
   end

   assign req_stall          = (state_ff != rsr_pkg::ST_IDLE);
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_out_tag        = rsp_ent_ff.tag;
   assign rsp_out_dept       = rsp_ent_ff.dept;
   assign rsp_out_score      = rsp_ent_ff.score;
   assign rsp_run_number     = rsp_ent_ff.run;
   assign rsp_heap_now_empty = rsp_empty_ff;

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      32'(count_ff) <= 32'(CAPACITY))
      else $error("heap count above capacity");

   a_rsp_from_top: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !$past(rsp_valid_ff && rsp_stall)) |->
         $past(state_ff == rsr_pkg::ST_TOP))
      else $error("result loaded outside top read");

   a_hole_in_heap: assert property (@(posedge clock) disable iff (reset)
      (state_ff == rsr_pkg::ST_DN_L) |-> (CW'(idx_ff) < n_ff))
      else $error("sift-down hole beyond heap size");

   a_write_in_range: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (32'(wr_addr) < 32'(CAPACITY)))
      else $error("heap write out of range");
`endif

endmodule
